[rtl/assert_macros.svh]
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define GSA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked out of reset.
`define GSA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[rtl/gsa_pkg.sv]
`timescale 1ns / 1ps
package gsa_pkg;

    localparam int MAX_TOTAL_LENGTH = 1024;
    localparam int ALPHABET_SIZE    = 26;
    localparam int NODE_STORE       = 2 * MAX_TOTAL_LENGTH;
    localparam int NODE_W           = 11;
    localparam int SYM_W            = 5;
    localparam int TR_DEPTH         = NODE_STORE * ALPHABET_SIZE;
    localparam int TR_AW            = $clog2(TR_DEPTH);
    localparam int CNT_W            = $clog2(ALPHABET_SIZE + 1);

    localparam logic [NODE_W-1:0] ROOT_NODE = NODE_W'(1);
    localparam logic [NODE_W-1:0] NULL_NODE = NODE_W'(0);

    typedef struct packed {
        logic [4:0] symbol;
        logic       first_of_string;
    } item_t;

    typedef struct packed {
        logic [10:0] node_reached;
        logic [10:0] node_length;
        logic [10:0] node_total;
        logic        store_full;
    } result_t;

    typedef struct packed {
        logic [NODE_W-1:0] len;
        logic [NODE_W-1:0] link;
    } meta_t;

    typedef struct packed {
        logic              start;
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] len;
        logic [SYM_W-1:0]  sym;
    } req_t;

    typedef struct packed {
        logic              done;
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] len;
        logic [NODE_W-1:0] total;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_T,
        ST_T,
        ST_RM,
        ST_CLR,
        ST_L0,
        ST_L1,
        ST_L2,
        ST_L3,
        ST_SP_CP,
        ST_SW,
        ST_SW1,
        ST_SW2,
        ST_SFIN_R,
        ST_SFIN_Q,
        ST_DONE
    } seq_state_t;

    function automatic logic [TR_AW-1:0] tr_addr(logic [NODE_W-1:0] node,
                                                 logic [SYM_W-1:0] k);
        tr_addr = TR_AW'(node) * TR_AW'(ALPHABET_SIZE) + TR_AW'(k);
    endfunction

endpackage

[rtl/gsa_ram.sv]
`timescale 1ns / 1ps
module gsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/gsa_seq.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gsa_seq (
    input  logic          clk,
    input  logic          rst_n,
    input  gsa_pkg::req_t req,
    input  logic          ack,
    output gsa_pkg::rsp_t rsp
);
    import gsa_pkg::*;

    seq_state_t state_reg, state_next;
    logic [NODE_W-1:0] p_reg, p_next, plen_reg, plen_next;
    logic [SYM_W-1:0]  sym_reg, sym_next;
    logic [NODE_W-1:0] r_reg, r_next, rlen_reg, rlen_next, rlink_reg, rlink_next;
    logic [NODE_W-1:0] q_reg, q_next, qlen_reg, qlen_next;
    logic [NODE_W-1:0] o_reg, o_next, olen_reg, olen_next;
    logic [NODE_W-1:0] cnt_node_reg, cnt_node_next;
    logic [NODE_W-1:0] res_node_reg, res_node_next, res_len_reg, res_len_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              ret_q_reg, ret_q_next;
    logic              rd_root_t_reg, rd_root_t_next, rd_root_m_reg, rd_root_m_next;
    logic [ALPHABET_SIZE-1:0] root_vld_reg, root_vld_next;

    logic              tr_we;
    logic [TR_AW-1:0]  tr_waddr, tr_raddr;
    logic [NODE_W-1:0] tr_wdata, tr_rdata, tr_val;
    logic              m_we;
    logic [NODE_W-1:0] m_waddr, m_raddr;
    meta_t             m_wdata, m_rdata, m_val;

    gsa_ram #(.WIDTH(NODE_W), .DEPTH(TR_DEPTH)) u_tr (
        .clk   (clk),
        .we    (tr_we),
        .waddr (tr_waddr),
        .wdata (tr_wdata),
        .raddr (tr_raddr),
        .rdata (tr_rdata)
    );

    gsa_ram #(.WIDTH($bits(meta_t)), .DEPTH(NODE_STORE)) u_meta (
        .clk   (clk),
        .we    (m_we),
        .waddr (m_waddr),
        .wdata (m_wdata),
        .raddr (m_raddr),
        .rdata (m_rdata)
    );

    // The root row and root entry read through their reset values until written.
    assign tr_val = (rd_root_t_reg && !root_vld_reg[sym_reg]) ? NULL_NODE : tr_rdata;
    assign m_val  = rd_root_m_reg ? '0 : m_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_node_reg  <= ROOT_NODE;
            root_vld_reg  <= '0;
            rd_root_t_reg <= 1'b0;
            rd_root_m_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_node_reg  <= cnt_node_next;
            root_vld_reg  <= root_vld_next;
            rd_root_t_reg <= rd_root_t_next;
            rd_root_m_reg <= rd_root_m_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg        <= p_next;
        plen_reg     <= plen_next;
        sym_reg      <= sym_next;
        r_reg        <= r_next;
        rlen_reg     <= rlen_next;
        rlink_reg    <= rlink_next;
        q_reg        <= q_next;
        qlen_reg     <= qlen_next;
        o_reg        <= o_next;
        olen_reg     <= olen_next;
        res_node_reg <= res_node_next;
        res_len_reg  <= res_len_next;
        cnt_reg      <= cnt_next;
        ret_q_reg    <= ret_q_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        p_next         = p_reg;
        plen_next      = plen_reg;
        sym_next       = sym_reg;
        r_next         = r_reg;
        rlen_next      = rlen_reg;
        rlink_next     = rlink_reg;
        q_next         = q_reg;
        qlen_next      = qlen_reg;
        o_next         = o_reg;
        olen_next      = olen_reg;
        cnt_node_next  = cnt_node_reg;
        res_node_next  = res_node_reg;
        res_len_next   = res_len_reg;
        cnt_next       = cnt_reg;
        ret_q_next     = ret_q_reg;
        root_vld_next  = root_vld_reg;
        rd_root_t_next = 1'b0;
        rd_root_m_next = 1'b0;
        tr_we          = 1'b0;
        tr_waddr       = '0;
        tr_wdata       = NULL_NODE;
        tr_raddr       = '0;
        m_we           = 1'b0;
        m_waddr        = NULL_NODE;
        m_wdata        = '0;
        m_raddr        = NULL_NODE;
        rsp            = '0;
        rsp.total      = cnt_node_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.start)
                begin
                    p_next     = req.node;
                    plen_next  = req.len;
                    sym_next   = req.sym;
                    state_next = ST_RD_T;
                end
            end
            ST_RD_T:
            begin
                tr_raddr       = tr_addr(p_reg, sym_reg);
                rd_root_t_next = (p_reg == ROOT_NODE);
                state_next     = ST_T;
            end
            ST_T:
            begin
                r_next = tr_val;
                if (tr_val != NULL_NODE)
                begin
                    m_raddr    = tr_val;
                    state_next = ST_RM;
                end
                else
                begin
                    q_next        = cnt_node_reg + NODE_W'(1);
                    qlen_next     = plen_reg + NODE_W'(1);
                    cnt_node_next = cnt_node_reg + NODE_W'(1);
                    cnt_next      = '0;
                    state_next    = ST_CLR;
                end
            end
            ST_RM:
            begin
                rlen_next  = m_val.len;
                rlink_next = m_val.link;
                if (m_val.len == plen_reg + NODE_W'(1))
                begin
                    res_node_next = r_reg;
                    res_len_next  = m_val.len;
                    state_next    = ST_DONE;
                end
                else
                begin
                    ret_q_next    = 1'b0;
                    o_next        = cnt_node_reg + NODE_W'(1);
                    olen_next     = plen_reg + NODE_W'(1);
                    cnt_node_next = cnt_node_reg + NODE_W'(1);
                    cnt_next      = '0;
                    state_next    = ST_SP_CP;
                end
            end
            ST_CLR:
            begin
                tr_we    = 1'b1;
                tr_waddr = tr_addr(q_reg, SYM_W'(cnt_reg));
                tr_wdata = NULL_NODE;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(ALPHABET_SIZE - 1))
                begin
                    state_next = ST_L0;
                end
            end
            ST_L0:
            begin
                tr_we    = 1'b1;
                tr_waddr = tr_addr(p_reg, sym_reg);
                tr_wdata = q_reg;
                if (p_reg == ROOT_NODE)
                begin
                    root_vld_next[sym_reg] = 1'b1;
                end
                m_raddr        = p_reg;
                rd_root_m_next = (p_reg == ROOT_NODE);
                state_next     = ST_L1;
            end
            ST_L1:
            begin
                p_next = m_val.link;
                if (m_val.link == NULL_NODE)
                begin
                    m_we          = 1'b1;
                    m_waddr       = q_reg;
                    m_wdata.len   = qlen_reg;
                    m_wdata.link  = ROOT_NODE;
                    res_node_next = q_reg;
                    res_len_next  = qlen_reg;
                    state_next    = ST_DONE;
                end
                else
                begin
                    tr_raddr       = tr_addr(m_val.link, sym_reg);
                    rd_root_t_next = (m_val.link == ROOT_NODE);
                    m_raddr        = m_val.link;
                    rd_root_m_next = (m_val.link == ROOT_NODE);
                    state_next     = ST_L2;
                end
            end
            ST_L2:
            begin
                plen_next = m_val.len;
                if (tr_val == NULL_NODE)
                begin
                    state_next = ST_L0;
                end
                else
                begin
                    r_next     = tr_val;
                    m_raddr    = tr_val;
                    state_next = ST_L3;
                end
            end
            ST_L3:
            begin
                rlen_next  = m_val.len;
                rlink_next = m_val.link;
                if (m_val.len == plen_reg + NODE_W'(1))
                begin
                    m_we          = 1'b1;
                    m_waddr       = q_reg;
                    m_wdata.len   = qlen_reg;
                    m_wdata.link  = r_reg;
                    res_node_next = q_reg;
                    res_len_next  = qlen_reg;
                    state_next    = ST_DONE;
                end
                else
                begin
                    ret_q_next    = 1'b1;
                    o_next        = cnt_node_reg + NODE_W'(1);
                    olen_next     = plen_reg + NODE_W'(1);
                    cnt_node_next = cnt_node_reg + NODE_W'(1);
                    cnt_next      = '0;
                    state_next    = ST_SP_CP;
                end
            end
            ST_SP_CP:
            begin
                if (cnt_reg != CNT_W'(ALPHABET_SIZE))
                begin
                    tr_raddr = tr_addr(r_reg, SYM_W'(cnt_reg));
                end
                if (cnt_reg != '0)
                begin
                    tr_we    = 1'b1;
                    tr_waddr = tr_addr(o_reg, SYM_W'(cnt_reg - CNT_W'(1)));
                    tr_wdata = tr_rdata;
                end
                else
                begin
                    m_we         = 1'b1;
                    m_waddr      = o_reg;
                    m_wdata.len  = olen_reg;
                    m_wdata.link = rlink_reg;
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(ALPHABET_SIZE))
                begin
                    state_next = ST_SW;
                end
            end
            ST_SW:
            begin
                tr_we    = 1'b1;
                tr_waddr = tr_addr(p_reg, sym_reg);
                tr_wdata = o_reg;
                if (p_reg == ROOT_NODE)
                begin
                    root_vld_next[sym_reg] = 1'b1;
                end
                m_raddr        = p_reg;
                rd_root_m_next = (p_reg == ROOT_NODE);
                state_next     = ST_SW1;
            end
            ST_SW1:
            begin
                p_next = m_val.link;
                if (m_val.link == NULL_NODE)
                begin
                    state_next = ST_SFIN_R;
                end
                else
                begin
                    tr_raddr       = tr_addr(m_val.link, sym_reg);
                    rd_root_t_next = (m_val.link == ROOT_NODE);
                    state_next     = ST_SW2;
                end
            end
            ST_SW2:
            begin
                state_next = (tr_val == r_reg) ? ST_SW : ST_SFIN_R;
            end
            ST_SFIN_R:
            begin
                m_we         = 1'b1;
                m_waddr      = r_reg;
                m_wdata.len  = rlen_reg;
                m_wdata.link = o_reg;
                if (ret_q_reg)
                begin
                    state_next = ST_SFIN_Q;
                end
                else
                begin
                    res_node_next = o_reg;
                    res_len_next  = olen_reg;
                    state_next    = ST_DONE;
                end
            end
            ST_SFIN_Q:
            begin
                m_we          = 1'b1;
                m_waddr       = q_reg;
                m_wdata.len   = qlen_reg;
                m_wdata.link  = o_reg;
                res_node_next = q_reg;
                res_len_next  = qlen_reg;
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                rsp.done = 1'b1;
                rsp.node = res_node_reg;
                rsp.len  = res_len_reg;
                if (ack)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `GSA_ASSERT_IMP(a_start_idle, req.start, state_reg == ST_IDLE)
    `GSA_ASSERT_NXT(a_count_grows, 1'b1, cnt_node_reg >= $past(cnt_node_reg))
    `GSA_ASSERT_IMP(a_done_node, state_reg == ST_DONE, res_node_reg != NULL_NODE)
    `GSA_ASSERT_IMP(a_root_untouched, m_we, m_waddr != ROOT_NODE)

endmodule

[rtl/general_suffix_automaton_build.sv]
// Channel  | Payload            | Handshake
// item     | gsa_pkg::item_t    | item_valid, item_stall
// result   | gsa_pkg::result_t  | result_valid, result_stall
//
// An ignored symbol (store full or letter out of range) returns its beat in the next cycle.
// A reused node finishes after the transition and meta reads; a new node also clears its row,
// walks the suffix links and, for each clone, copies a row and redirects transitions to the clone.
// Reset clears the root row through valid bits, so no clearing pass follows reset.
// A new item is taken while a finished beat waits, as long as the walk has ended;
// an ignored symbol waits until the result register is free.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module general_suffix_automaton_build (
    input  logic             clk,
    input  logic             rst_n,
    input  gsa_pkg::item_t   item,
    input  logic             item_valid,
    output logic             item_stall,
    output gsa_pkg::result_t result,
    output logic             result_valid,
    input  logic             result_stall
);
    import gsa_pkg::*;

    logic [NODE_W-1:0] cur_reg, cur_next, cur_len_reg, cur_len_next;
    logic              busy_reg, busy_next, result_valid_reg, result_valid_next;
    result_t           result_reg, result_next;
    req_t              req;
    rsp_t              rsp;
    logic              accept, out_free, ack, full, bad_sym;
    logic [NODE_W-1:0] start_node, start_len;

    gsa_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .ack   (ack),
        .rsp   (rsp)
    );

    assign out_free     = !result_valid_reg || !result_stall;
    assign item_stall   = busy_reg || (!out_free && (full || bad_sym));
    assign accept       = item_valid && !item_stall;
    assign ack          = busy_reg && rsp.done && out_free;
    assign result       = result_reg;
    assign result_valid = result_valid_reg;
    assign start_node   = item.first_of_string ? ROOT_NODE : cur_reg;
    assign start_len    = item.first_of_string ? NULL_NODE : cur_len_reg;
    assign full         = rsp.total >= NODE_W'(NODE_STORE - 2);
    assign bad_sym      = item.symbol >= SYM_W'(ALPHABET_SIZE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg          <= ROOT_NODE;
            cur_len_reg      <= '0;
            busy_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            cur_reg          <= cur_next;
            cur_len_reg      <= cur_len_next;
            busy_reg         <= busy_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_comb
    begin
        cur_next          = cur_reg;
        cur_len_next      = cur_len_reg;
        busy_next         = busy_reg;
        result_valid_next = result_valid_reg && result_stall;
        result_next       = result_reg;
        req               = '0;
        req.node          = start_node;
        req.len           = start_len;
        req.sym           = item.symbol;
        if (accept)
        begin
            if (full || bad_sym)
            begin
                cur_next                 = start_node;
                cur_len_next             = start_len;
                result_valid_next        = 1'b1;
                result_next.node_reached = start_node;
                result_next.node_length  = start_len;
                result_next.node_total   = rsp.total;
                result_next.store_full   = full;
            end
            else
            begin
                req.start = 1'b1;
                busy_next = 1'b1;
            end
        end
        if (ack)
        begin
            cur_next                 = rsp.node;
            cur_len_next             = rsp.len;
            busy_next                = 1'b0;
            result_valid_next        = 1'b1;
            result_next.node_reached = rsp.node;
            result_next.node_length  = rsp.len;
            result_next.node_total   = rsp.total;
            result_next.store_full   = 1'b0;
        end
    end

    `GSA_ASSERT_IMP(a_no_accept_busy, busy_reg, !accept)
    `GSA_ASSERT_NXT(a_start_busy, req.start, busy_reg)
    `GSA_ASSERT_NXT(a_ack_result, ack, result_valid && !result.store_full)

endmodule
